>>> hw/rtl/mtsm_pkg.sv
// ----------------------------------------------------------------------------
// mtsm_pkg: shared constants and helpers of the multi-tone sine mixer
// Register codes, reset values, polynomial coefficients and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mtsm_pkg;

  // default geometry, handed to the top level parameters
  localparam int NUM_TONES_DEF       = 4;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 3;
  localparam int TUNE_REGS   = 4;
  localparam int TUNE_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_TONE_COUNT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE_ON_MASK  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TUNING_WORD_A = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TUNING_WORD_B = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TUNING_WORD_C = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TUNING_WORD_D = 3'd5;

  // register reset values
  localparam logic [COUNT_W-1:0]   TONE_COUNT_RST    = 3'd1;
  localparam logic [TUNE_REGS-1:0] TONE_ON_MASK_RST  = 4'd1;
  localparam logic [TUNE_W-1:0]    TUNING_WORD_A_RST = 32'd944892805;

  // datapath widths
  localparam int SAMPLE_W    = 16;
  localparam int AMP_W       = 15;
  localparam int MAG_W       = 15;
  localparam int X_W         = 17;
  localparam int LANE_STAGES = 6;
  localparam int QUEUE_DEPTH = 4;

  // odd polynomial coefficients of the quarter-wave sine, Q16
  localparam int unsigned SIN_A = 102944;
  localparam int unsigned SIN_B = 42334;
  localparam int unsigned SIN_C = 5223;
  localparam int unsigned SIN_D = 307;

  localparam logic [MAG_W-1:0] MAG_MAX = 15'h7fff;

  // per-tone amplitude floor(65535 / (2 * count)); zero count acts as one
  function automatic logic [AMP_W-1:0] amp_for_count(input logic [COUNT_W-1:0] count);
    logic [AMP_W-1:0] amp;
    unique case (count)
      3'd2:    amp = 15'd16383;
      3'd3:    amp = 15'd10922;
      3'd4:    amp = 15'd8191;
      3'd5:    amp = 15'd6553;
      3'd6:    amp = 15'd5461;
      3'd7:    amp = 15'd4681;
      default: amp = 15'd32767;
    endcase
    return amp;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mtsm_front.sv
// ----------------------------------------------------------------------------
// mtsm_front: input side of the mixer
// Holds the config registers and phase accumulators; while the queue has room,
// takes one beat per cycle and pushes its phases, enables and amplitude.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_front
  import mtsm_pkg::*;
#(
  parameter int NUM_TONES  = NUM_TONES_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [CFG_INDEX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  restart,
  input  logic                                  queue_full,
  output logic                                  push,
  output logic [NUM_TONES-1:0][PHASE_BITS-1:0]  push_phase,
  output logic [NUM_TONES-1:0]                  push_on,
  output logic [AMP_W-1:0]                      push_amp
);

  logic [COUNT_W-1:0]                 tone_count;
  logic [TUNE_REGS-1:0]               tone_on_mask;
  logic [TUNE_REGS-1:0][TUNE_W-1:0]   tuning_word;
  logic [NUM_TONES-1:0][PHASE_BITS-1:0] tone_phase;
  logic [NUM_TONES-1:0][PHASE_BITS-1:0] tone_phase_next;
  logic [COUNT_W-1:0]                 count_eff;

  // write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_count   <= TONE_COUNT_RST;
      tone_on_mask <= TONE_ON_MASK_RST;
      tuning_word  <= (TUNE_REGS*TUNE_W)'(TUNING_WORD_A_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TONE_COUNT:    tone_count     <= cfg_data[COUNT_W-1:0];
        REG_TONE_ON_MASK:  tone_on_mask   <= cfg_data[TUNE_REGS-1:0];
        REG_TUNING_WORD_A: tuning_word[0] <= cfg_data[TUNE_W-1:0];
        REG_TUNING_WORD_B: tuning_word[1] <= cfg_data[TUNE_W-1:0];
        REG_TUNING_WORD_C: tuning_word[2] <= cfg_data[TUNE_W-1:0];
        REG_TUNING_WORD_D: tuning_word[3] <= cfg_data[TUNE_W-1:0];
        default: ;
      endcase
    end
  end

  assign count_eff = (tone_count == '0) ? COUNT_W'(1) : tone_count;
  assign push_amp  = amp_for_count(tone_count);

  // accept whenever the queue has room
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // phases of this beat and the advance that follows it
  for (genvar i = 0; i < NUM_TONES; i++) begin : g_tone
    assign push_phase[i] = restart ? '0 : tone_phase[i];
    if (i < TUNE_REGS) begin : g_listed
      assign push_on[i]         = tone_on_mask[i] && (COUNT_W'(i) < count_eff);
      assign tone_phase_next[i] = push_phase[i] + PHASE_BITS'(tuning_word[i]);
    end else begin : g_unlisted
      assign push_on[i]         = 1'b0;
      assign tone_phase_next[i] = push_phase[i];
    end
  end

  // advance accumulators on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_phase <= '0;
    end else if (push) begin
      tone_phase <= tone_phase_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mtsm_queue.sv
// ----------------------------------------------------------------------------
// mtsm_queue: short queue between the front and the back of the mixer
// Circular buffer of flat entries with a fill count; head read directly.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_queue
  import mtsm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full    = (fill == (PTR_W+1)'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = entry[rd_ptr];

  // store incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mtsm_lane.sv
// ----------------------------------------------------------------------------
// mtsm_lane: one tone of the mixer back end
// Six-stage pipeline: quarter-wave fold, Horner evaluation of the sine
// polynomial one multiply per stage, clamp, then amplitude scaling and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_lane
  import mtsm_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [PHASE_BITS-1:0]      phase,
  input  logic                       on,
  input  logic [AMP_W-1:0]           amp,
  output logic signed [SAMPLE_W-1:0] term
);

  localparam int QUAD_BITS = TABLE_ADDR_BITS - 2;
  localparam int X_SHIFT   = 16 - QUAD_BITS;

  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [1:0]                 quad0;
  logic [X_W-1:0]             x_fwd;
  logic [X_W-1:0]             x0;
  logic [2*X_W-1:0]           p_sq;
  logic [25:0]                p_d;
  logic [12:0]                c_minus;
  logic [29:0]                p_c;
  logic [15:0]                b_minus;
  logic [32:0]                p_b;
  logic [16:0]                a_minus;
  logic [33:0]                p_a;
  logic [16:0]                half;
  logic [29:0]                p_m;
  logic [MAG_W-1:0]           term_mag;

  // stage registers
  logic [X_W-1:0]   x_s1, x_s2, x_s3, x_s4;
  logic [X_W-1:0]   x2_s1, x2_s2, x2_s3;
  logic [1:0]       quad_s1, quad_s2, quad_s3, quad_s4, quad_s5;
  logic             on_s1, on_s2, on_s3, on_s4, on_s5;
  logic [AMP_W-1:0] amp_s1, amp_s2, amp_s3, amp_s4, amp_s5;
  logic [9:0]       t1_s2;
  logic [13:0]      t2_s3;
  logic [16:0]      t3_s4;
  logic [MAG_W-1:0] mag_s5;

  // fold phase into the first quadrant, Q16
  assign addr  = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign quad0 = addr[TABLE_ADDR_BITS-1 -: 2];
  assign x_fwd = {1'b0, addr[QUAD_BITS-1:0], {X_SHIFT{1'b0}}};
  assign x0    = quad0[0] ? (X_W'(65536) - x_fwd) : x_fwd;
  assign p_sq  = x0 * x0;

  // Horner steps, inner products truncated by 16 bits, the outer one by 17
  assign p_d     = 26'(SIN_D) * 26'(x2_s1);
  assign c_minus = 13'(SIN_C) - 13'(t1_s2);
  assign p_c     = 30'(c_minus) * 30'(x2_s2);
  assign b_minus = 16'(SIN_B) - 16'(t2_s3);
  assign p_b     = 33'(b_minus) * 33'(x2_s3);
  assign a_minus = 17'(SIN_A) - t3_s4;
  assign p_a     = 34'(a_minus) * 34'(x_s4);
  assign half    = p_a[33:17];

  // scale by amplitude, truncate toward zero
  assign p_m      = 30'(mag_s5) * 30'(amp_s5);
  assign term_mag = p_m[29:15];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: square
      x_s1    <= x0;
      x2_s1   <= p_sq[32:16];
      quad_s1 <= quad0;
      on_s1   <= on;
      amp_s1  <= amp;
      // stage 2: innermost term
      x_s2    <= x_s1;
      x2_s2   <= x2_s1;
      t1_s2   <= p_d[25:16];
      quad_s2 <= quad_s1;
      on_s2   <= on_s1;
      amp_s2  <= amp_s1;
      // stage 3
      x_s3    <= x_s2;
      x2_s3   <= x2_s2;
      t2_s3   <= p_c[29:16];
      quad_s3 <= quad_s2;
      on_s3   <= on_s2;
      amp_s3  <= amp_s2;
      // stage 4
      x_s4    <= x_s3;
      t3_s4   <= p_b[32:16];
      quad_s4 <= quad_s3;
      on_s4   <= on_s3;
      amp_s4  <= amp_s3;
      // stage 5: outer multiply, halve to Q15 and clamp
      mag_s5  <= (half > 17'(MAG_MAX)) ? MAG_MAX : half[MAG_W-1:0];
      quad_s5 <= quad_s4;
      on_s5   <= on_s4;
      amp_s5  <= amp_s4;
      // stage 6: signed, gated contribution
      if (!on_s5) begin
        term <= '0;
      end else if (quad_s5[1]) begin
        term <= -$signed({1'b0, term_mag});
      end else begin
        term <= $signed({1'b0, term_mag});
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mtsm_back.sv
// ----------------------------------------------------------------------------
// mtsm_back: output side of the mixer
// Pops queued beats into one lane per tone, sums the lane contributions
// modulo 2^16, negates and holds the sample in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_back
  import mtsm_pkg::*;
#(
  parameter int NUM_TONES       = NUM_TONES_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 queue_empty,
  output logic                                 pop,
  input  logic [NUM_TONES-1:0][PHASE_BITS-1:0] pop_phase,
  input  logic [NUM_TONES-1:0]                 pop_on,
  input  logic [AMP_W-1:0]                     pop_amp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_W-1:0]           sample
);

  logic                                 en;
  logic [LANE_STAGES:0]                 vld;
  logic [NUM_TONES-1:0][PHASE_BITS-1:0] phase_s0;
  logic [NUM_TONES-1:0]                 on_s0;
  logic [AMP_W-1:0]                     amp_s0;
  logic signed [SAMPLE_W-1:0]           term [NUM_TONES];
  logic signed [SAMPLE_W-1:0]           sum;

  // advance the whole pipe while the output register is free or being taken
  assign en  = !out_valid || !out_stall;
  assign pop = en && !queue_empty;

  // entry stage and valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[LANE_STAGES-1:0], pop};
      out_valid <= vld[LANE_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_s0 <= pop_phase;
      on_s0    <= pop_on;
      amp_s0   <= pop_amp;
    end
  end

  for (genvar i = 0; i < NUM_TONES; i++) begin : g_lane
    mtsm_lane #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .phase (phase_s0[i]),
      .on    (on_s0[i]),
      .amp   (amp_s0),
      .term  (term[i])
    );
  end

  // wrap-around sum of the lanes
  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_TONES; i++) begin
      sum = sum + term[i];
    end
  end

  // output register, negated sum
  always_ff @(posedge clk) begin
    if (en) begin
      sample <= -sum;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/multi_tone_sine_mixer.sv
// ----------------------------------------------------------------------------
// multi_tone_sine_mixer: multi-tone direct digital synthesiser
// Each beat in gives one 16-bit sample mixing up to NUM_TONES sine tones.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   restart
//   output    out        out_valid/out_stall sample
//   config    in         cfg_write           cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; each lane
// stage holds one multiplier. Synchronous reset clears phases, queue and
// valid chain and loads the registers with their reset values.
// A stalled output freezes the back pipe; the front keeps taking beats
// into a four-entry queue and stalls its input only when that is full.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_tone_sine_mixer
  import mtsm_pkg::*;
#(
  parameter int NUM_TONES       = NUM_TONES_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int PHASE_W = NUM_TONES * PHASE_BITS;
  localparam int ENTRY_W = PHASE_W + NUM_TONES + AMP_W;

  logic                                 push;
  logic                                 pop;
  logic                                 queue_full;
  logic                                 queue_empty;
  logic [NUM_TONES-1:0][PHASE_BITS-1:0] push_phase;
  logic [NUM_TONES-1:0]                 push_on;
  logic [AMP_W-1:0]                     push_amp;
  logic [NUM_TONES-1:0][PHASE_BITS-1:0] pop_phase;
  logic [NUM_TONES-1:0]                 pop_on;
  logic [AMP_W-1:0]                     pop_amp;
  logic [ENTRY_W-1:0]                   wr_entry;
  logic [ENTRY_W-1:0]                   rd_entry;

  mtsm_front #(
    .NUM_TONES  (NUM_TONES),
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .queue_full (queue_full),
    .push       (push),
    .push_phase (push_phase),
    .push_on    (push_on),
    .push_amp   (push_amp)
  );

  // pack and unpack queue entries
  assign wr_entry  = {push_amp, push_on, push_phase};
  assign pop_phase = rd_entry[PHASE_W-1:0];
  assign pop_on    = rd_entry[PHASE_W +: NUM_TONES];
  assign pop_amp   = rd_entry[ENTRY_W-1 -: AMP_W];

  mtsm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  mtsm_back #(
    .NUM_TONES       (NUM_TONES),
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop         (pop),
    .pop_phase   (pop_phase),
    .pop_on      (pop_on),
    .pop_amp     (pop_amp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mtsm_checker.sv
// ----------------------------------------------------------------------------
// mtsm_checker: port-level checks of the multi-tone sine mixer
// Watches reset behaviour, output holding and queue back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_checker
  import mtsm_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] sample
);

  // a stalled sample stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample))
    else $error("stalled sample changed or was dropped");

  // no sample straight out of reset
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("sample valid right after reset");

  // queue empty after reset, so input is open
  a_reset_in: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

  // queue only fills while a finished sample waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no sample waiting");

  // input never stalled while the output holds no sample
  a_stall_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall && !out_valid |-> 1'b0)
    else $error("input stalled while output idle");

endmodule

bind multi_tone_sine_mixer mtsm_checker u_checker (.*);

`default_nettype wire
